### design/rfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared widths, operation codes and decode helpers for the register file ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int OP_W    = 4;
  localparam int NIB_W   = 4;
  localparam int VALUE_W = 64;

  // Instruction operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
  localparam logic [OP_W-1:0] OP_MOD  = 4'd4;
  localparam logic [OP_W-1:0] OP_INC  = 4'd5;
  localparam logic [OP_W-1:0] OP_DEC  = 4'd6;
  localparam logic [OP_W-1:0] OP_ADDI = 4'd7;
  localparam logic [OP_W-1:0] OP_SUBI = 4'd8;
  localparam logic [OP_W-1:0] OP_MULI = 4'd9;
  localparam logic [OP_W-1:0] OP_DIVI = 4'd10;
  localparam logic [OP_W-1:0] OP_MODI = 4'd11;

  // Internal ALU function codes
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_MOD,
    ALU_PASS
  } alu_fn_t;

  typedef enum logic [1:0] {
    SRC_REG,
    SRC_ONE,
    SRC_IMM
  } opnd_sel_t;

  function automatic alu_fn_t alu_fn(input logic [OP_W-1:0] op);
    alu_fn_t fn;
    case (op)
      OP_ADD, OP_INC, OP_ADDI: fn = ALU_ADD;
      OP_SUB, OP_DEC, OP_SUBI: fn = ALU_SUB;
      OP_MUL, OP_MULI:         fn = ALU_MUL;
      OP_DIV, OP_DIVI:         fn = ALU_DIV;
      OP_MOD, OP_MODI:         fn = ALU_MOD;
      default:                 fn = ALU_PASS;
    endcase
    return fn;
  endfunction

  function automatic opnd_sel_t opnd_sel(input logic [OP_W-1:0] op);
    opnd_sel_t sel;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: sel = SRC_REG;
      OP_INC, OP_DEC:                         sel = SRC_ONE;
      default:                                sel = SRC_IMM;
    endcase
    return sel;
  endfunction

endpackage

### design/rfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_req_if / rfa_rsp_if
// Valid/ready channels carrying ALU requests and register write reports.
// ----------------------------------------------------------------------------
interface rfa_req_if;
  import rfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [NIB_W-1:0]   src_reg;
  logic [NIB_W-1:0]   dst_reg;
  logic [VALUE_W-1:0] immediate;

  modport source (output valid, operation, src_reg, dst_reg, immediate, input ready);
  modport sink   (input valid, operation, src_reg, dst_reg, immediate, output ready);
endinterface

interface rfa_rsp_if;
  import rfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [NIB_W-1:0]   written_reg;
  logic [VALUE_W-1:0] written_value;
  logic               divide_by_zero;

  modport source (output valid, written_reg, written_value, divide_by_zero, input ready);
  modport sink   (input valid, written_reg, written_value, divide_by_zero, output ready);
endinterface

### design/rfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/register_file_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_file_integer_alu
// Sequential integer ALU working on a register file of unsigned registers.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) takes one decoded instruction per request: operation, the two
//   register nibbles and a 64-bit immediate. rsp (source) returns one report
//   per request: the register written, its new value and a divide-by-zero flag.
//   Register nibbles are reduced modulo REG_COUNT; codes 12 to 15 write nothing
//   and report the current value of the src_reg register.
// Sequence:
//   The RDA and RDB states read the operands through the register file RAM
//   port, then the shared adder runs in EXEC: add, sub, inc and dec use it
//   once, while mul, div and mod iterate over the DATA_WIDTH operand bits, one
//   multiplier or quotient bit per iteration. FIN then writes back and loads
//   the result register, holding while rsp is stalled. req.ready is high
//   only while no request is in flight.
// Reset and stalls:
//   rst clears the register file through per-register valid bits and empties
//   the result register. A request may be taken while a result waits; if rsp
//   stays stalled, the next result holds in the write-back step.
// ----------------------------------------------------------------------------
module register_file_integer_alu #(
  parameter int REG_COUNT  = 16,
  parameter int DATA_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  rfa_req_if.sink  req,
  rfa_rsp_if.source rsp
);
  import rfa_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam int NIB_COUNT = 2 ** NIB_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Nibble to register index, reduced at elaboration
  logic [IDX_W-1:0] idx_tbl [NIB_COUNT];
  for (genvar g = 0; g < NIB_COUNT; g++) begin : g_idx
    assign idx_tbl[g] = IDX_W'(g % REG_COUNT);
  end

  logic [2:0]            state;
  logic [OP_W-1:0]       op;
  logic [IDX_W-1:0]      src_idx;
  logic [IDX_W-1:0]      dst_idx;
  logic [DATA_WIDTH-1:0] imm;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic [DATA_WIDTH-1:0] acc;
  logic [CNT_W-1:0]      cnt;
  logic                  dz;
  logic [REG_COUNT-1:0]  reg_valid;
  logic                  rd_valid;
  logic                  rsp_valid;

  alu_fn_t   fn;
  opnd_sel_t sel;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      target;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [DATA_WIDTH-1:0] operand;
  logic [DATA_WIDTH-1:0] b_src;
  logic [DATA_WIDTH-1:0] result;
  logic                  out_free;
  logic                  we;

  // Shared adder/subtractor
  logic [DATA_WIDTH:0]   ux;
  logic [DATA_WIDTH:0]   uy;
  logic                  usub;
  logic [DATA_WIDTH+1:0] usum;

  assign fn      = alu_fn(op);
  assign sel     = opnd_sel(op);
  assign target  = (sel == SRC_REG) ? dst_idx : src_idx;
  assign operand = rd_valid ? ram_rdata : '0;
  assign out_free = !rsp_valid || rsp.ready;
  assign we      = (state == S_FIN) && out_free && (fn != ALU_PASS);

  always_comb begin
    unique case (state)
      S_IDLE: begin
        rd_addr = (opnd_sel(req.operation) == SRC_REG) ? idx_tbl[req.dst_reg]
                                                       : idx_tbl[req.src_reg];
      end
      default: rd_addr = src_idx;
    endcase
  end

  always_comb begin
    unique case (sel)
      SRC_REG: b_src = operand;
      SRC_ONE: b_src = DATA_WIDTH'(1);
      default: b_src = imm;
    endcase
  end

  always_comb begin
    ux   = {1'b0, a};
    uy   = {1'b0, b};
    usub = 1'b0;
    priority case (fn)
      ALU_MUL: begin
        ux = {1'b0, acc};
        uy = {1'b0, a};
      end
      ALU_DIV, ALU_MOD: begin
        ux   = {acc, a[DATA_WIDTH-1]};
        usub = 1'b1;
      end
      ALU_SUB: usub = 1'b1;
      default: usub = 1'b0;
    endcase
    usum = {1'b0, ux} + {1'b0, uy ^ {(DATA_WIDTH+1){usub}}} + (DATA_WIDTH+2)'(usub);
  end

  assign result = (fn == ALU_DIV) ? a : acc;

  rfa_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .we   (we),
    .waddr(target),
    .wdata(result),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      reg_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= reg_valid[rd_addr];
      // load a new report, or drop the one just taken
      if ((state == S_FIN) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op      <= req.operation;
            src_idx <= idx_tbl[req.src_reg];
            dst_idx <= idx_tbl[req.dst_reg];
            imm     <= req.immediate[DATA_WIDTH-1:0];
            state   <= S_RDA;
          end
        end
        S_RDA: begin
          a     <= operand;
          state <= S_RDB;
        end
        S_RDB: begin
          b     <= b_src;
          acc   <= '0;
          cnt   <= CNT_W'(DATA_WIDTH - 1);
          dz    <= ((fn == ALU_DIV) || (fn == ALU_MOD)) && (b_src == '0);
          state <= S_EXEC;
        end
        S_EXEC: begin
          priority case (fn)
            ALU_MUL: begin
              if (b[0]) begin
                acc <= usum[DATA_WIDTH-1:0];
              end
              a <= a << 1;
              b <= b >> 1;
            end
            ALU_DIV, ALU_MOD: begin
              // keep the difference when the trial subtract does not borrow
              if (usum[DATA_WIDTH+1]) begin
                acc <= usum[DATA_WIDTH-1:0];
              end else begin
                acc <= ux[DATA_WIDTH-1:0];
              end
              a <= {a[DATA_WIDTH-2:0], usum[DATA_WIDTH+1]};
            end
            ALU_PASS: acc <= a;
            default:  acc <= usum[DATA_WIDTH-1:0];
          endcase
          if ((fn == ALU_MUL) || (fn == ALU_DIV) || (fn == ALU_MOD)) begin
            if (cnt == '0) begin
              state <= S_FIN;
            end else begin
              cnt <= cnt - CNT_W'(1);
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold here until the result register frees up
          if (out_free) begin
            rsp.written_reg    <= NIB_W'(target);
            rsp.written_value  <= VALUE_W'(result);
            rsp.divide_by_zero <= dz;
            if (we) begin
              reg_valid[target] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
